FILE: rtl/core/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared widths, codes and helpers for the slot bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

   localparam int USABLE_W = 11;
   localparam int BYTES_W  = 16;
   localparam int OFFS_W   = 14;
   localparam int FREEB_W  = 15;
   localparam int STATUS_W = 2;
   localparam int NEED_W   = 5;
   localparam int SKIP_W   = 4;

   typedef logic [1:0] code_type;

   localparam code_type CODE_FREE    = 2'd0;
   localparam code_type CODE_ONE     = 2'd1;
   localparam code_type CODE_FIVE    = 2'd2;
   localparam code_type CODE_SIXTEEN = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [16:0] SIZE_FIVE    = 17'd80;
   localparam logic [16:0] SIZE_SIXTEEN = 17'd256;

   localparam logic [USABLE_W-1:0] USABLE_RESET = 11'd1024;

   // Control that every cell of the ring sees
   typedef struct packed {
      logic clear;
      logic shift;
   } ring_ctl_type;

   // Slots covered by one run of the given code
   function automatic logic [NEED_W-1:0] run_len(input code_type c);
      logic [NEED_W-1:0] n;
      case (c)
         CODE_FIVE:    n = 5'd5;
         CODE_SIXTEEN: n = 5'd16;
         default:      n = 5'd1;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sba_if.sv
// ----------------------------------------------------------------------------
// sba_if
// Channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [sba_pkg::BYTES_W-1:0] request_bytes;
   logic [sba_pkg::OFFS_W-1:0]  byte_offset;

   modport source (output valid, mode, request_bytes, byte_offset, input ready);
   modport sink   (input valid, mode, request_bytes, byte_offset, output ready);
endinterface

interface sba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sba_pkg::STATUS_W-1:0] status;
   logic [sba_pkg::OFFS_W-1:0]   alloc_offset;
   logic [sba_pkg::FREEB_W-1:0]  free_bytes;

   modport source (output valid, status, alloc_offset, free_bytes, input ready);
   modport sink   (input valid, status, alloc_offset, free_bytes, output ready);
endinterface

interface sba_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sba_pkg::USABLE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sba_cell.sv
// ----------------------------------------------------------------------------
// sba_cell
// One slot of the code ring: holds a 2-bit code, takes its neighbor's on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sba_pkg::ring_ctl_type ctl,
   input  wire sba_pkg::code_type     nbr_code,
   output sba_pkg::code_type          code
);

   sba_pkg::code_type code_ff;

   // Clear on reset or pool re-init, advance on shift
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         code_ff <= sba_pkg::CODE_FREE;
      end else if (ctl.shift) begin
         code_ff <= nbr_code;
      end
   end

   assign code = code_ff;

endmodule

`default_nettype wire

FILE: rtl/core/slot_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_bitmap_allocator_top
// First-fit allocator of 16-byte slots over a rotating ring of code cells.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per handshake; mode 0 allocates request_bytes,
//          mode 1 frees the run at byte_offset.
//   rsp  : one response per request with status, alloc_offset and the free
//          byte count after the request.
//   csr  : writes usable_slots; every write clears the pool. Always ready.
// Timing:
//   The slot codes sit in a ring of SLOTS cells that rotates one slot per
//   cycle past a head cell during the scan and write laps. A request that
//   needs the pool scans one full lap, decides, and makes one more lap to
//   write when it succeeds. Requests rejected on their fields or on the
//   free count skip the laps. One request is in flight at a time.
// Reset:
//   All slots free, usable_slots 1024, free count set to the usable slots.
// Stall:
//   A response waits in its output register; the next request is accepted
//   and worked on, and its response holds until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_bitmap_allocator_top #(
   parameter int SLOTS = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sba_req_if.sink    req,
   sba_rsp_if.source  rsp,
   sba_csr_if.sink    csr
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = (IW + 1 > 12) ? IW + 1 : 12;
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [IW-1:0] LAST_POS = IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_EVAL, S_WRITE, S_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // Code ring
   // ------------------------------------------------------------------------
   sba_pkg::ring_ctl_type ring_ctl;
   sba_pkg::code_type     codes [SLOTS];
   sba_pkg::code_type     wrap_code;
   sba_pkg::code_type     head;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      if (k == SLOTS - 1) begin : g_tail
         sba_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ring_ctl),
            .nbr_code(wrap_code), .code(codes[k])
         );
      end else begin : g_body
         sba_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ring_ctl),
            .nbr_code(codes[k+1]), .code(codes[k])
         );
      end
   end

   assign head = codes[0];

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   state_type                     state_ff, state_in;
   logic [IW-1:0]                 pos_ff, pos_in;
   logic                          mode_ff, mode_in;
   logic [CW-1:0]                 slot_ff, slot_in;
   logic [sba_pkg::NEED_W-1:0]    need_ff, need_in;
   sba_pkg::code_type             code_ff, code_in;
   logic [sba_pkg::NEED_W-1:0]    cnt_ff, cnt_in;
   logic [sba_pkg::SKIP_W-1:0]    skip_ff, skip_in;
   logic [IW-1:0]                 first_ff, first_in;
   logic                          found_ff, found_in;
   logic                          mism_ff, mism_in;
   logic [sba_pkg::USABLE_W-1:0]  usable_ff, usable_in;
   logic [sba_pkg::USABLE_W-1:0]  free_ff, free_in;
   logic [sba_pkg::STATUS_W-1:0]  st_ff, st_in;
   logic [sba_pkg::OFFS_W-1:0]    aoff_ff, aoff_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sba_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [sba_pkg::OFFS_W-1:0]    rsp_aoff_ff, rsp_aoff_in;
   logic [sba_pkg::FREEB_W-1:0]   rsp_fbytes_ff, rsp_fbytes_in;

   logic                          req_fire, csr_fire;
   logic [CW-1:0]                 lim, pos_ext, run_end, wr_end, req_slot;
   logic [16:0]                   rounded;
   logic [sba_pkg::NEED_W-1:0]    req_need, run_n;
   sba_pkg::code_type             req_code;
   logic                          last_pos, in_write;

   // Effective pool size: the register clamped to the ring length
   function automatic logic [CW-1:0] eff_usable(input logic [sba_pkg::USABLE_W-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      return (w > SLOTS_C) ? SLOTS_C : w;
   endfunction

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid && csr.ready;

   assign lim      = eff_usable(usable_ff);
   assign pos_ext  = CW'(pos_ff);
   assign last_pos = (pos_ff == LAST_POS);
   assign req_slot = CW'(req.byte_offset[sba_pkg::OFFS_W-1:4]);
   assign run_n    = sba_pkg::run_len(code_ff);
   assign run_end  = slot_ff + CW'(run_n);
   assign wr_end   = CW'(first_ff) + CW'(need_ff);

   // Round the allocate size and pick the run length
   always_comb begin
      rounded  = (17'(req.request_bytes) + 17'd7) & ~17'd7;
      req_need = 5'd1;
      req_code = sba_pkg::CODE_ONE;
      if (rounded == sba_pkg::SIZE_FIVE) begin
         req_need = 5'd5;
         req_code = sba_pkg::CODE_FIVE;
      end
      if (rounded == sba_pkg::SIZE_SIXTEEN) begin
         req_need = 5'd16;
         req_code = sba_pkg::CODE_SIXTEEN;
      end
   end

   // Rewrite slots as they leave the head during the write lap
   always_comb begin
      in_write  = 1'b0;
      wrap_code = head;
      if (state_ff == S_WRITE) begin
         if (mode_ff == sba_pkg::MODE_ALLOC) begin
            in_write = (pos_ext >= CW'(first_ff)) && (pos_ext < wr_end);
            if (in_write) wrap_code = code_ff;
         end else begin
            in_write = (pos_ext >= slot_ff) && (pos_ext < run_end);
            if (in_write) wrap_code = sba_pkg::CODE_FREE;
         end
      end
      ring_ctl.clear = csr_fire;
      ring_ctl.shift = (state_ff == S_SCAN) || (state_ff == S_WRITE);
   end

   // ------------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      need_in       = need_ff;
      code_in       = code_ff;
      cnt_in        = cnt_ff;
      skip_in       = skip_ff;
      first_in      = first_ff;
      found_in      = found_ff;
      mism_in       = mism_ff;
      usable_in     = usable_ff;
      free_in       = free_ff;
      st_in         = st_ff;
      aoff_in       = aoff_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_aoff_in   = rsp_aoff_ff;
      rsp_fbytes_in = rsp_fbytes_ff;

      case (state_ff)
         // Take a request and screen its fields and the free count
         S_IDLE: begin
            if (req_fire) begin
               mode_in  = req.mode;
               slot_in  = req_slot;
               need_in  = req_need;
               code_in  = (req.mode == sba_pkg::MODE_ALLOC) ? req_code
                                                           : sba_pkg::CODE_FREE;
               cnt_in   = '0;
               skip_in  = '0;
               first_in = '0;
               found_in = 1'b0;
               mism_in  = 1'b0;
               pos_in   = '0;
               aoff_in  = '0;
               state_in = S_SCAN;
               if (req.mode == sba_pkg::MODE_ALLOC) begin
                  if (req.request_bytes == '0) begin
                     st_in    = sba_pkg::ST_BAD;
                     state_in = S_DONE;
                  end else if (free_ff < 11'(req_need)) begin
                     st_in    = sba_pkg::ST_NOSPACE;
                     state_in = S_DONE;
                  end
               end else if ((req.byte_offset[3:0] != 4'd0) || (req_slot >= lim)) begin
                  st_in    = sba_pkg::ST_BAD;
                  state_in = S_DONE;
               end
            end
         end

         // One lap: first-fit search or run check at the head cell
         S_SCAN: begin
            pos_in = last_pos ? '0 : pos_ff + 1'b1;
            if (mode_ff == sba_pkg::MODE_ALLOC) begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end else if (!found_ff && (pos_ext < lim)) begin
                  if (head == sba_pkg::CODE_FREE) begin
                     if (cnt_ff == '0) first_in = pos_ff;
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_ff + 1'b1 == need_ff) found_in = 1'b1;
                  end else begin
                     cnt_in  = '0;
                     skip_in = 4'(sba_pkg::run_len(head) - 1'b1);
                  end
               end
            end else begin
               if (pos_ext == slot_ff) begin
                  code_in = head;
               end else if ((pos_ext > slot_ff) && (pos_ext < run_end) &&
                            (head != code_ff)) begin
                  mism_in = 1'b1;
               end
            end
            if (last_pos) state_in = S_EVAL;
         end

         // Decide on the scan outcome
         S_EVAL: begin
            state_in = S_WRITE;
            if (mode_ff == sba_pkg::MODE_ALLOC) begin
               if (!found_ff) begin
                  st_in    = sba_pkg::ST_NOSPACE;
                  state_in = S_DONE;
               end
            end else if ((code_ff == sba_pkg::CODE_FREE) || (run_end > lim) || mism_ff) begin
               st_in    = sba_pkg::ST_NOTALLOC;
               state_in = S_DONE;
            end
         end

         // One lap writing the run, then settle the free count
         S_WRITE: begin
            pos_in = last_pos ? '0 : pos_ff + 1'b1;
            if (last_pos) begin
               st_in    = sba_pkg::ST_OK;
               state_in = S_DONE;
               if (mode_ff == sba_pkg::MODE_ALLOC) begin
                  free_in = free_ff - 11'(need_ff);
                  aoff_in = 14'({first_ff, 4'b0000});
               end else begin
                  free_in = free_ff + 11'(run_n);
               end
            end
         end

         // Hand the response to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_aoff_in   = aoff_ff;
               rsp_fbytes_in = {free_ff, 4'b0000};
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Register write re-initializes the pool
      if (csr_fire) begin
         usable_in = csr.data;
         free_in   = 11'(eff_usable(csr.data));
      end
   end

   // ------------------------------------------------------------------------
   // State and registered outputs
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         usable_ff    <= sba_pkg::USABLE_RESET;
         free_ff      <= 11'(eff_usable(sba_pkg::USABLE_RESET));
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         usable_ff    <= usable_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      need_ff       <= need_in;
      code_ff       <= code_in;
      cnt_ff        <= cnt_in;
      skip_ff       <= skip_in;
      first_ff      <= first_in;
      found_ff      <= found_in;
      mism_ff       <= mism_in;
      st_ff         <= st_in;
      aoff_ff       <= aoff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_aoff_ff   <= rsp_aoff_in;
      rsp_fbytes_ff <= rsp_fbytes_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.alloc_offset = rsp_aoff_ff;
   assign rsp.free_bytes   = rsp_fbytes_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status != sba_pkg::ST_OK) |-> rsp.alloc_offset == '0)
      else $error("failed request reports an offset");

   a_free_in_pool: assert property (@(posedge clock) disable iff (reset)
      CW'(free_ff) <= lim)
      else $error("free count exceeds the pool");

   a_lap_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && !last_pos |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("ring position skipped during a lap");

endmodule

`default_nettype wire

FILE: dv/slot_bitmap_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// slot_bitmap_allocator_top_tb
// Drives allocate and free requests into the slot allocator and checks each
// response against a behavioral copy of the pool, over several pool sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_bitmap_allocator_top_tb;

   localparam int NSLOT     = 1024;
   localparam int WDOG_MAX  = 40000;
   localparam int N_RANDOM  = 1950;

   typedef struct packed {
      logic                         mode;
      logic [sba_pkg::BYTES_W-1:0]  request_bytes;
      logic [sba_pkg::OFFS_W-1:0]   byte_offset;
   } sba_req_type;

   typedef struct packed {
      logic [sba_pkg::STATUS_W-1:0] status;
      logic [sba_pkg::OFFS_W-1:0]   alloc_offset;
      logic [sba_pkg::FREEB_W-1:0]  free_bytes;
   } sba_rsp_type;

   // Directed row: request, whether a typed answer is given, the answer
   typedef struct packed {
      sba_req_type rq;
      logic        fixed;
      sba_rsp_type rs;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sba_req_if req ();
   sba_rsp_if rsp ();
   sba_csr_if csr ();

   slot_bitmap_allocator_top #(.SLOTS(NSLOT)) u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #5 clock = ~clock;

   // Behavioral pool state
   sba_pkg::code_type            pool_codes [NSLOT];
   logic [sba_pkg::USABLE_W-1:0] pool_usable;
   int unsigned                  pool_free;

   sba_rsp_type resp_queue [$];
   logic        fixed_queue [$];
   sba_rsp_type fixed_resp_queue [$];

   int mismatches = 0;
   int resp_count = 0;
   int wdog = 0;
   bit timed_out = 0;
   int n_alloc_ok = 0, n_free_ok = 0;

   function automatic int unsigned span_of(input sba_pkg::code_type c);
      return (c == sba_pkg::CODE_FIVE) ? 5 : (c == sba_pkg::CODE_SIXTEEN) ? 16 : 1;
   endfunction

   function automatic int unsigned pool_limit();
      return (pool_usable > NSLOT) ? NSLOT : pool_usable;
   endfunction

   task automatic pool_reinit(input logic [sba_pkg::USABLE_W-1:0] v);
      pool_usable = v;
      foreach (pool_codes[i]) pool_codes[i] = sba_pkg::CODE_FREE;
      pool_free = pool_limit();
   endtask

   // Compute the response to one request and update the pool
   function automatic sba_rsp_type pool_apply(input sba_req_type r);
      sba_rsp_type       o;
      int unsigned       lim, sz, need, p, cnt, first, slot, n;
      sba_pkg::code_type c, code;
      bit                found, ok;
      lim = pool_limit();
      o = '0;
      if (r.mode == sba_pkg::MODE_ALLOC) begin
         if (r.request_bytes == 0) begin
            o.status = sba_pkg::ST_BAD;
         end else begin
            sz = (r.request_bytes + 7) & ~7;
            need = 1; code = sba_pkg::CODE_ONE;
            if (sz == 80) begin need = 5; code = sba_pkg::CODE_FIVE; end
            if (sz == 256) begin need = 16; code = sba_pkg::CODE_SIXTEEN; end
            found = 0; p = 0; cnt = 0; first = 0;
            while (!found && p < lim) begin
               c = pool_codes[p];
               if (c == sba_pkg::CODE_FREE) begin
                  if (cnt == 0) first = p;
                  cnt++;
                  if (cnt == need) found = 1;
               end else begin
                  cnt = 0;
               end
               p += span_of(c);
            end
            if (pool_free == 0 || pool_free < need || !found) begin
               o.status = sba_pkg::ST_NOSPACE;
            end else begin
               for (int k = 0; k < need; k++) pool_codes[first + k] = code;
               pool_free -= need;
               o.alloc_offset = sba_pkg::OFFS_W'(first * 16);
               n_alloc_ok++;
            end
         end
      end else begin
         slot = r.byte_offset >> 4;
         if (r.byte_offset[3:0] != 0 || slot >= lim) begin
            o.status = sba_pkg::ST_BAD;
         end else begin
            c = pool_codes[slot];
            if (c == sba_pkg::CODE_FREE) begin
               o.status = sba_pkg::ST_NOTALLOC;
            end else begin
               n = span_of(c);
               ok = (slot + n <= lim);
               for (int k = 1; ok && k < n; k++)
                  if (pool_codes[slot + k] != c) ok = 0;
               if (!ok) begin
                  o.status = sba_pkg::ST_NOTALLOC;
               end else begin
                  for (int k = 0; k < n; k++) pool_codes[slot + k] = sba_pkg::CODE_FREE;
                  pool_free += n;
                  n_free_ok++;
               end
            end
         end
      end
      o.free_bytes = sba_pkg::FREEB_W'(pool_free * 16);
      return o;
   endfunction

   // Receiver: random stalls, compare against oldest expectation
   initial begin
      int gap;
      sba_rsp_type got, want;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got = '{rsp.status, rsp.alloc_offset, rsp.free_bytes};
         resp_count++;
         if (resp_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = resp_queue.pop_front();
            if (fixed_queue.pop_front()) begin
               sba_rsp_type typed;
               typed = fixed_resp_queue.pop_front();
               if (typed != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("table row disagrees: typed %p predicted %p", typed, want);
               end
            end else begin
               void'(fixed_resp_queue.pop_front());
            end
            if (got.status != want.status || got.alloc_offset != want.alloc_offset ||
                got.free_bytes != want.free_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st=%0d off=%0d free=%0d %s",
                           want.status, want.alloc_offset, want.free_bytes,
                           $sformatf("got st=%0d off=%0d free=%0d",
                                     got.status, got.alloc_offset, got.free_bytes));
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         wdog <= 0;
      else
         wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         timed_out = 1;
         $display("watchdog expired");
         $display("status: fail");
         $finish;
      end
   end

   // Send one request and record its expected response
   task automatic send_request(input sba_req_type r, input logic fx, input sba_rsp_type typed);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.mode          <= r.mode;
      req.request_bytes <= r.request_bytes;
      req.byte_offset   <= r.byte_offset;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      resp_queue.push_back(pool_apply(r));
      fixed_queue.push_back(fx);
      fixed_resp_queue.push_back(typed);
   endtask

   // Write usable_slots once the pool is quiet
   task automatic write_usable(input logic [sba_pkg::USABLE_W-1:0] v);
      req.valid <= 1'b0;
      while (resp_queue.size() != 0) @(posedge clock);
      repeat (2 * NSLOT + 10) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      pool_reinit(v);
   endtask

   function automatic sba_req_type rand_request(input int unsigned lim);
      sba_req_type r;
      int unsigned sel;
      r.mode = 1'($urandom_range(0, 1));
      r.request_bytes = sba_pkg::BYTES_W'($urandom);
      r.byte_offset = sba_pkg::OFFS_W'($urandom);
      sel = $urandom_range(0, 9);
      if (r.mode == sba_pkg::MODE_ALLOC) begin
         // Favor sizes that map to the multi-slot runs
         if (sel < 3) r.request_bytes = sba_pkg::BYTES_W'($urandom_range(73, 80));
         else if (sel < 5) r.request_bytes = sba_pkg::BYTES_W'($urandom_range(249, 256));
         else if (sel < 8) r.request_bytes = sba_pkg::BYTES_W'($urandom_range(1, 200));
      end else if (sel < 8 && lim > 0) begin
         // Mostly aligned frees inside the pool
         r.byte_offset = sba_pkg::OFFS_W'($urandom_range(0, lim - 1) * 16);
      end
      return r;
   endfunction

   dir_row_type dir_table [] = '{
      '{'{sba_pkg::MODE_ALLOC, 16'd0,     14'd0},  1'b1,
        '{sba_pkg::ST_BAD,      14'd0,  15'd16384}},
      '{'{sba_pkg::MODE_ALLOC, 16'd1,     14'd0},  1'b1,
        '{sba_pkg::ST_OK,       14'd0,  15'd16368}},
      '{'{sba_pkg::MODE_ALLOC, 16'd80,    14'd0},  1'b1,
        '{sba_pkg::ST_OK,       14'd16, 15'd16288}},
      '{'{sba_pkg::MODE_ALLOC, 16'd256,   14'd0},  1'b1,
        '{sba_pkg::ST_OK,       14'd96, 15'd16032}},
      '{'{sba_pkg::MODE_ALLOC, 16'd65535, 14'd0},  1'b0, '0},
      '{'{sba_pkg::MODE_ALLOC, 16'd73,    14'd0},  1'b0, '0},
      '{'{sba_pkg::MODE_ALLOC, 16'd249,   14'd0},  1'b0, '0},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd8},  1'b1,
        '{sba_pkg::ST_BAD,      14'd0,  15'd15680}},
      '{'{sba_pkg::MODE_FREE,  16'hffff,  14'd16383}, 1'b1,
        '{sba_pkg::ST_BAD,      14'd0,  15'd15680}},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd16368}, 1'b1,
        '{sba_pkg::ST_NOTALLOC, 14'd0,  15'd15680}},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd32},  1'b0, '0},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd16},  1'b0, '0},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd0},   1'b0, '0},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd0},   1'b0, '0},
      '{'{sba_pkg::MODE_FREE,  16'd0,     14'd96},  1'b0, '0}
   };

   // Stimulus
   initial begin
      logic [sba_pkg::USABLE_W-1:0] sizes [6] =
         '{11'd1, 11'd2047, 11'd17, 11'd1024, 11'd40, 11'd200};
      req.valid <= 1'b0; req.mode <= 1'b0; req.request_bytes <= '0; req.byte_offset <= '0;
      csr.valid <= 1'b0; csr.data <= '0;
      pool_reinit(sba_pkg::USABLE_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_table[i]) send_request(dir_table[i].rq, dir_table[i].fixed, dir_table[i].rs);
      // Zero usable slots: every allocate reports no space and a free is rejected
      write_usable(11'd0);
      send_request('{sba_pkg::MODE_ALLOC, 16'd1, 14'd0}, 1'b1,
                   '{sba_pkg::ST_NOSPACE, 14'd0, 15'd0});
      send_request('{sba_pkg::MODE_FREE, 16'd0, 14'd0}, 1'b1,
                   '{sba_pkg::ST_BAD, 14'd0, 15'd0});
      // Random phases across pool sizes; large pools get fewer requests
      foreach (sizes[s]) begin
         int unsigned n;
         write_usable(sizes[s]);
         n = (sizes[s] >= 1024) ? 150 : (N_RANDOM - 300) / 4;
         repeat (n) send_request(rand_request(pool_limit()), 1'b0, '0);
      end
      req.valid <= 1'b0;
      while (resp_queue.size() != 0) @(posedge clock);
      repeat (2 * NSLOT + 10) @(posedge clock);
      $display("covered %0d responses: %0d allocations and %0d frees succeeded",
               resp_count, n_alloc_ok, n_free_ok);
      $display("pool sizes 0, 1, 17, 40, 200, 1024 and 2047 were exercised");
      if (mismatches == 0 && resp_queue.size() == 0 && !timed_out)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/sba_pkg.sv
rtl/core/sba_if.sv
rtl/core/sba_cell.sv
rtl/core/slot_bitmap_allocator_top.sv
dv/slot_bitmap_allocator_top_tb.sv
